// ===== rtl/core/tbp_pkg.sv =====
// ============================================================================
// Tournament branch predictor package
// Shared types, sizes and counter helpers for the predictor block.
// ============================================================================
package tbp_pkg;

    // Table geometry. Every table has one 2-bit counter per entry.
    localparam int TABLE_ENTRIES = 2048;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    // Global history: at most HIST_W bits, length set by a 4-bit register.
    localparam int HIST_W = 11;
    localparam int HB_W   = 4;
    localparam logic [HB_W-1:0] HB_RESET = HB_W'(HIST_W);

    // Width used to combine address bits and history before indexing.
    localparam int XW = (IDX_W > HIST_W) ? IDX_W : HIST_W;

    // Two-bit saturating counters.
    localparam int CTR_W = 2;
    localparam logic [CTR_W-1:0] CTR_MAX        = 2'b11;
    localparam logic [CTR_W-1:0] CTR_MIN        = 2'b00;
    localparam logic [CTR_W-1:0] CTR_PRED_RESET = 2'b11;
    localparam logic [CTR_W-1:0] CTR_SEL_RESET  = 2'b00;

    // Running count of correct predictions.
    localparam int CNT_W = 32;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Queue between the front and back parts, and the result buffer.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [31:0] branch_address;
        logic        taken;
    } t_branch;

    typedef struct packed {
        logic             predicted_taken;
        logic             gshare_prediction;
        logic             bimodal_prediction;
        logic             chose_bimodal;
        logic             prediction_correct;
        logic [CNT_W-1:0] correct_total;
    } t_result;

    // Classified branch handed from the front part to the back part.
    typedef struct packed {
        logic [IDX_W-1:0] g_idx;
        logic [IDX_W-1:0] b_idx;
        logic             taken;
    } t_req;

    // Step a counter one place toward the outcome, saturating at both ends.
    function automatic logic [CTR_W-1:0] ctr_train(input logic [CTR_W-1:0] c,
                                                   input logic up);
        logic [CTR_W-1:0] r;
        if (up) begin
            r = (c == CTR_MAX) ? CTR_MAX : c + CTR_W'(1);
        end else begin
            r = (c == CTR_MIN) ? CTR_MIN : c - CTR_W'(1);
        end
        return r;
    endfunction

    // Mask with the low hb bits set.
    function automatic logic [HIST_W-1:0] hist_mask(input logic [HB_W-1:0] hb);
        logic [HIST_W-1:0] m;
        m = '0;
        for (int i = 0; i < HIST_W; i++) begin
            m[i] = (HB_W'(i) < hb);
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/tbp_ram.sv =====
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port, read data registered, old data on
// a same-address read and write.
// ============================================================================
module tbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/tbp_front.sv =====
// ============================================================================
// Predictor front part
// Holds the history length register and the global history, accepts
// resolved branches and turns each into table indices.
// ============================================================================
module tbp_front import tbp_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [HB_W-1:0] i_cfg_wr_data,
    input  logic            i_br_valid,
    output logic            o_br_ready,
    input  t_branch         i_br,
    input  logic            i_q_ready,
    input  logic            i_clearing,
    output logic            o_q_push,
    output t_req            o_q_data
);

    logic [HB_W-1:0]   r_history_bits;
    logic [HIST_W-1:0] r_hist;
    logic [HIST_W-1:0] n_hist;
    logic [HB_W-1:0]   hb_eff;
    logic [IDX_W-1:0]  b_idx;
    logic [XW-1:0]     g_mix;
    logic              accept;

    assign o_br_ready = i_q_ready && !i_clearing;
    assign accept     = i_br_valid && o_br_ready;

    // Lengths above the history width behave as the full width.
    assign hb_eff = (r_history_bits > HB_W'(HIST_W)) ? HB_W'(HIST_W) : r_history_bits;

    assign b_idx = i_br.branch_address[IDX_W-1:0];
    assign g_mix = XW'(b_idx) ^ XW'(r_hist);
    assign n_hist = {r_hist[HIST_W-2:0], i_br.taken} & hist_mask(hb_eff);

    assign o_q_push       = accept;
    assign o_q_data.g_idx = g_mix[IDX_W-1:0];
    assign o_q_data.b_idx = b_idx;
    assign o_q_data.taken = i_br.taken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_history_bits <= HB_RESET;
            r_hist         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_history_bits <= i_cfg_wr_data;
            end
            if (accept) begin
                r_hist <= n_hist;
            end
        end
    end

endmodule

// ===== rtl/core/tbp_queue.sv =====
// ============================================================================
// Front-to-back queue
// Small first-in first-out buffer of classified branches.
// ============================================================================
module tbp_queue import tbp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_data,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_req o_data
);

    t_req              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/core/tbp_back.sv =====
// ============================================================================
// Predictor back part
// Clears the counter tables after reset, reads and trains the three tables
// for each branch, keeps the correct count and buffers the results.
// ============================================================================
module tbp_back import tbp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_req    i_q_data,
    output logic    o_q_pop,
    output logic    o_clearing,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    // Clearing pass.
    logic             r_clr_active;
    logic [IDX_W-1:0] r_clr_idx;

    // Evaluate stage: the cycle in which the table read data is present.
    logic             r_e_valid;
    t_req             r_e;

    // Last written entries, for a branch that read in the cycle of that write.
    logic             r_fwd_valid;
    logic [IDX_W-1:0] r_fwd_g_idx;
    logic [IDX_W-1:0] r_fwd_b_idx;
    logic [CTR_W-1:0] r_fwd_g;
    logic [CTR_W-1:0] r_fwd_b;
    logic [CTR_W-1:0] r_fwd_s;

    logic [CNT_W-1:0] r_correct;
    logic [CNT_W-1:0] n_correct;

    // Result buffer.
    t_result           r_out_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_out_wr;
    logic [QPTR_W-1:0] r_out_rd;
    logic [QCNT_W-1:0] r_out_count;

    logic             issue;
    logic             out_pop;
    logic             we;
    logic [CTR_W-1:0] g_rdata, b_rdata, s_rdata;
    logic [CTR_W-1:0] g_ctr, b_ctr, s_ctr;
    logic [CTR_W-1:0] g_new, b_new, s_new;
    logic [IDX_W-1:0] g_waddr, b_waddr;
    logic [CTR_W-1:0] g_wdata, b_wdata, s_wdata;
    logic             g_pred, b_pred, sel_b, pred, g_ok, b_ok, ok;
    t_result          res;

    // A branch is issued only when the result buffer is sure to have room for
    // it and for the branch already in the evaluate stage.
    assign issue = !r_clr_active && i_q_valid
                   && ((r_out_count + QCNT_W'(r_e_valid)) < QCNT_W'(QUEUE_DEPTH));
    assign o_q_pop    = issue;
    assign o_clearing = r_clr_active;

    assign we      = r_clr_active || r_e_valid;
    assign g_waddr = r_clr_active ? r_clr_idx : r_e.g_idx;
    assign b_waddr = r_clr_active ? r_clr_idx : r_e.b_idx;
    assign g_wdata = r_clr_active ? CTR_PRED_RESET : g_new;
    assign b_wdata = r_clr_active ? CTR_PRED_RESET : b_new;
    assign s_wdata = r_clr_active ? CTR_SEL_RESET  : s_new;

    tbp_ram #(.WIDTH(CTR_W), .DEPTH(TABLE_ENTRIES)) u_gshare (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_raddr (i_q_data.g_idx),
        .o_rdata (g_rdata)
    );

    tbp_ram #(.WIDTH(CTR_W), .DEPTH(TABLE_ENTRIES)) u_bimodal (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (i_q_data.b_idx),
        .o_rdata (b_rdata)
    );

    tbp_ram #(.WIDTH(CTR_W), .DEPTH(TABLE_ENTRIES)) u_selector (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (b_waddr),
        .i_wdata (s_wdata),
        .i_raddr (i_q_data.b_idx),
        .o_rdata (s_rdata)
    );

    always_comb begin
        g_ctr = (r_fwd_valid && (r_fwd_g_idx == r_e.g_idx)) ? r_fwd_g : g_rdata;
        b_ctr = (r_fwd_valid && (r_fwd_b_idx == r_e.b_idx)) ? r_fwd_b : b_rdata;
        s_ctr = (r_fwd_valid && (r_fwd_b_idx == r_e.b_idx)) ? r_fwd_s : s_rdata;

        g_pred = g_ctr[CTR_W-1];
        b_pred = b_ctr[CTR_W-1];
        sel_b  = s_ctr[CTR_W-1];
        pred   = sel_b ? b_pred : g_pred;
        g_ok   = (g_pred == r_e.taken);
        b_ok   = (b_pred == r_e.taken);
        ok     = (pred == r_e.taken);

        g_new = ctr_train(g_ctr, r_e.taken);
        b_new = ctr_train(b_ctr, r_e.taken);
        s_new = (g_ok != b_ok) ? ctr_train(s_ctr, b_ok) : s_ctr;

        n_correct = (ok && (r_correct != CNT_MAX)) ? r_correct + CNT_W'(1) : r_correct;

        res.predicted_taken    = pred;
        res.gshare_prediction  = g_pred;
        res.bimodal_prediction = b_pred;
        res.chose_bimodal      = sel_b;
        res.prediction_correct = ok;
        res.correct_total      = n_correct;
    end

    assign o_res_valid = (r_out_count != '0);
    assign o_res       = r_out_mem[r_out_rd];
    assign out_pop     = o_res_valid && i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_idx    <= '0;
            r_e_valid    <= 1'b0;
            r_fwd_valid  <= 1'b0;
            r_correct    <= '0;
            r_out_wr     <= '0;
            r_out_rd     <= '0;
            r_out_count  <= '0;
        end else begin
            if (r_clr_active) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
                if (r_clr_idx == '1) begin
                    r_clr_active <= 1'b0;
                end
            end
            r_e_valid   <= issue;
            r_fwd_valid <= r_e_valid;
            if (r_e_valid) begin
                r_correct <= n_correct;
                r_out_wr  <= r_out_wr + QPTR_W'(1);
            end
            if (out_pop) begin
                r_out_rd <= r_out_rd + QPTR_W'(1);
            end
            r_out_count <= r_out_count + QCNT_W'(r_e_valid) - QCNT_W'(out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_e <= i_q_data;
        end
        if (r_e_valid) begin
            r_fwd_g_idx          <= r_e.g_idx;
            r_fwd_b_idx          <= r_e.b_idx;
            r_fwd_g              <= g_new;
            r_fwd_b              <= b_new;
            r_fwd_s              <= s_new;
            r_out_mem[r_out_wr]  <= res;
        end
    end

    // The result buffer never holds more than its depth.
    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("result buffer overflow");

    // A branch in the evaluate stage always finds room in the result buffer.
    a_e_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid |-> (r_out_count < QCNT_W'(QUEUE_DEPTH)))
        else $error("evaluate stage without buffer room");

    // No branch is evaluated while the tables are still being cleared.
    a_no_eval_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !r_e_valid)
        else $error("branch evaluated during clearing pass");

    // The correct count never goes down.
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_correct >= $past(r_correct)))
        else $error("correct count decreased");

endmodule

// ===== rtl/core/tournament_branch_predictor_top.sv =====
// ============================================================================
// Tournament branch predictor
// Gshare and bimodal predictors with a per-address selector, trained by
// resolved branches one beat at a time.
// ============================================================================
// Each input beat is one resolved branch (address and outcome); each output
// beat reports what the predictor would have said for it before training:
// the gshare and bimodal predictions, which one the selector chose, the
// chosen prediction, whether it was right, and the running saturating count
// of right predictions. The block takes one branch per clock cycle and
// gives one result per cycle as long as the consumer keeps taking them;
// a result is offered once its branch has passed the front-to-back queue,
// the registered table read and the result buffer. Both queues are four
// beats deep, so a stalled consumer holds back the producer only once they
// fill. After reset the three 2048-entry counter tables are swept back to
// their reset values, one entry per cycle, so the input is not ready until
// the sweep ends; history length writes are taken during that time. The
// history length register must only be written while no branch is in
// flight. Lengths above eleven behave as eleven.
// ============================================================================
module tournament_branch_predictor_top import tbp_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // History length register.
    input  logic            i_cfg_wr_en,
    input  logic [HB_W-1:0] i_cfg_wr_data,
    // Resolved branches.
    input  logic            i_br_valid,
    output logic            o_br_ready,
    input  t_branch         i_br,
    // Prediction results.
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output t_result         o_res
);

    logic q_push;
    t_req q_in;
    logic q_ready;
    logic q_pop;
    logic q_valid;
    t_req q_out;
    logic clearing;

    // The front part updates the global history as soon as a branch is
    // accepted, since the history depends on the outcome alone; the tables
    // are read and trained later in the back part.
    tbp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_br_valid    (i_br_valid),
        .o_br_ready    (o_br_ready),
        .i_br          (i_br),
        .i_q_ready     (q_ready),
        .i_clearing    (clearing),
        .o_q_push      (q_push),
        .o_q_data      (q_in)
    );

    tbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // The back part forwards the last write to a branch that read the same
    // entry in the same cycle, so back-to-back branches to one entry train
    // correctly.
    tbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_out),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Tournament branch predictor testbench
// Streams resolved branches into the predictor under random backpressure on
// both channels and checks every result beat against a cycle-free software
// copy of the gshare, bimodal and selector tables, the global history and
// the running count of correct predictions.
// ============================================================================
module testbench;
    import tbp_pkg::*;

    // The table sweep after reset keeps the input closed, so the limit on
    // cycles without any beat leaves ample margin for it.
    localparam int WATCHDOG_LIMIT = 5 * TABLE_ENTRIES;
    // Extra wait after the last result, so that the pipeline settles.
    localparam int SETTLE_CYCLES   = 8;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int MAX_REPORTS     = 10;
    localparam int POOL            = 16;

    // History lengths, one per phase: the extremes, the reset value, a value
    // that is clamped to eleven and a couple in between.
    localparam logic [HB_W-1:0] HIST_LEN_SEQ [PHASES] = '{
        4'd15, 4'd0, 4'd11, 4'd1, 4'd12, 4'd6
    };

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the predictor state, computes the
    // result of every accepted branch and checks result beats in order.
    // ------------------------------------------------------------------------
    class predictor_scoreboard;
        logic [CTR_W-1:0]  gshare_tbl  [TABLE_ENTRIES];
        logic [CTR_W-1:0]  bimodal_tbl [TABLE_ENTRIES];
        logic [CTR_W-1:0]  select_tbl  [TABLE_ENTRIES];
        logic [HIST_W-1:0] ghist;
        logic [HB_W-1:0]   hist_len;
        logic [CNT_W-1:0]  hits;
        t_result           pending [$];
        int                errors;
        int                reports;

        function new();
            foreach (gshare_tbl[i]) begin
                gshare_tbl[i]  = CTR_PRED_RESET;
                bimodal_tbl[i] = CTR_PRED_RESET;
                select_tbl[i]  = CTR_SEL_RESET;
            end
            ghist    = '0;
            hits     = '0;
            hist_len = HB_RESET;
            errors   = 0;
            reports  = 0;
        endfunction

        function void set_hist_len(logic [HB_W-1:0] v);
            hist_len = v;
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        function logic [CTR_W-1:0] step_toward(logic [CTR_W-1:0] c, logic up);
            if (up) begin
                return (c == CTR_MAX) ? c : c + 1'b1;
            end
            return (c == CTR_MIN) ? c : c - 1'b1;
        endfunction

        function void note_branch(t_branch b);
            logic [IDX_W-1:0]  bi;
            logic [IDX_W-1:0]  gi;
            logic [HB_W-1:0]   len;
            logic [HIST_W-1:0] keep;
            logic              g_ok;
            logic              b_ok;
            t_result           r;
            bi = b.branch_address[IDX_W-1:0];
            gi = IDX_W'(XW'(bi) ^ XW'(ghist));
            // A counter predicts taken (or favors bimodal) in its upper half.
            r.gshare_prediction  = gshare_tbl[gi][CTR_W-1];
            r.bimodal_prediction = bimodal_tbl[bi][CTR_W-1];
            r.chose_bimodal      = select_tbl[bi][CTR_W-1];
            r.predicted_taken    = r.chose_bimodal ? r.bimodal_prediction
                                                   : r.gshare_prediction;
            r.prediction_correct = (r.predicted_taken == b.taken);
            if (r.prediction_correct && hits != CNT_MAX) begin
                hits = hits + 1'b1;
            end
            r.correct_total = hits;
            g_ok = (r.gshare_prediction == b.taken);
            b_ok = (r.bimodal_prediction == b.taken);
            if (g_ok != b_ok) begin
                select_tbl[bi] = step_toward(select_tbl[bi], b_ok);
            end
            len   = (hist_len > HIST_W) ? HB_W'(HIST_W) : hist_len;
            keep  = HIST_W'((32'd1 << len) - 32'd1);
            ghist = {ghist[HIST_W-2:0], b.taken} & keep;
            gshare_tbl[gi]  = step_toward(gshare_tbl[gi], b.taken);
            bimodal_tbl[bi] = step_toward(bimodal_tbl[bi], b.taken);
            pending.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                errors++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("%0t: result beat with no branch waiting: %p", $realtime, got);
                end
                return;
            end
            want = pending.pop_front();
            if (got.predicted_taken    !== want.predicted_taken    ||
                got.gshare_prediction  !== want.gshare_prediction  ||
                got.bimodal_prediction !== want.bimodal_prediction ||
                got.chose_bimodal      !== want.chose_bimodal      ||
                got.prediction_correct !== want.prediction_correct ||
                got.correct_total      !== want.correct_total) begin
                errors++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display({"%0t: mismatch pred/gs/bim/selb/ok/total ",
                              "expected %b%b%b%b%b %0d, got %b%b%b%b%b %0d"},
                             $realtime,
                             want.predicted_taken, want.gshare_prediction,
                             want.bimodal_prediction, want.chose_bimodal,
                             want.prediction_correct, want.correct_total,
                             got.predicted_taken, got.gshare_prediction,
                             got.bimodal_prediction, got.chose_bimodal,
                             got.prediction_correct, got.correct_total);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic            i_clk         = 1'b0;
    logic            i_rst_n       = 1'b0;
    logic            i_cfg_wr_en   = 1'b0;
    logic [HB_W-1:0] i_cfg_wr_data = '0;
    logic            i_br_valid    = 1'b0;
    logic            o_br_ready;
    t_branch         i_br          = '0;
    logic            o_res_valid;
    logic            i_res_ready   = 1'b0;
    t_result         o_res;

    // Percentages of cycles in which each side holds back.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stalled_cycles = 0;

    predictor_scoreboard sb = new();

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    tournament_branch_predictor_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_br_valid    (i_br_valid),
        .o_br_ready    (o_br_ready),
        .i_br          (i_br),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .o_res         (o_res)
    );

    // The receiver decides afresh every cycle whether it will take a beat.
    // A single assignment per edge keeps the value well defined.
    always @(posedge i_clk) begin
        i_res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor and watchdog. Values are read at the edge itself, so they are
    // the ones the block sees there: our inputs change only through
    // nonblocking assignments and the block's outputs come from its flops.
    // A beat in either direction resets the count of silent cycles.
    always @(posedge i_clk) begin
        if (i_rst_n && i_br_valid && o_br_ready) begin
            sb.note_branch(i_br);
        end
        if (i_rst_n && o_res_valid && i_res_ready) begin
            sb.check_result(o_res);
        end
        if (i_rst_n && ((i_br_valid && o_br_ready) || (o_res_valid && i_res_ready))) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles++;
        end
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("** tournament_branch_predictor_top: FAILED **");
            $finish;
        end
    end

    // Offer one branch and return at the edge where it is taken. Valid stays
    // high across back-to-back branches; it only drops for a random idle.
    task automatic send_branch(input logic [31:0] addr, input logic tk);
        t_branch b;
        b.branch_address = addr;
        b.taken          = tk;
        while ($urandom_range(99) < send_idle_pct) begin
            i_br_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_br_valid <= 1'b1;
        i_br       <= b;
        do begin
            @(posedge i_clk);
        end while (!o_br_ready);
    endtask

    // Stop sending, wait for every outstanding result, then let the pipeline
    // settle so that nothing is in flight when the register changes.
    task automatic drain_results();
        i_br_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (sb.outstanding() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_hist_len(input logic [HB_W-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_hist_len(v);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus.
    // Most random branches come from a small pool of branch sites, each with
    // its own repeating outcome pattern, so that the tables and the history
    // actually train and the selector moves both ways. Some pairs of sites
    // share a table index to exercise aliasing. The rest are near misses of
    // pool addresses and fully random branches.
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] site_pc  [POOL];
        logic [7:0]  site_pat [POOL];
        int          site_len [POOL];
        int          site_pos [POOL];
        logic [31:0] addr;
        logic        tk;
        int          pick;
        int          k;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            // First the sender idles a third of the time and the receiver
            // more than half, then the other way round, then neither idles.
            case (phase / 2)
                0: begin
                    send_idle_pct = 33;
                    recv_idle_pct = 59;
                end
                1: begin
                    send_idle_pct = 59;
                    recv_idle_pct = 33;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            // The first write lands while the tables are still being swept;
            // later ones wait for the pipeline to run empty.
            if (phase != 0) begin
                drain_results();
            end
            write_hist_len(HIST_LEN_SEQ[phase]);

            if (phase == 0) begin
                // Extremes of the address, aliasing on table entry zero and
                // the top entry, and two repeated sites whose outcomes flip so
                // that the components disagree and both agree.
                send_branch(32'h0000_0000, 1'b0);
                send_branch(32'hFFFF_FFFF, 1'b1);
                send_branch(32'h0000_0800, 1'b0);
                send_branch(32'hFFFF_F800, 1'b0);
                send_branch(32'h0000_07FF, 1'b1);
                send_branch(32'hAAAA_AAAA, 1'b1);
                send_branch(32'h5555_5555, 1'b0);
                for (int i = 0; i < 8; i++) begin
                    send_branch(32'h0000_1234, i[1]);
                end
                for (int i = 0; i < 8; i++) begin
                    send_branch(32'h8000_0040, (i != 3) && (i != 7));
                end
            end

            for (int i = 0; i < POOL; i++) begin
                if (i % 2 == 1 && $urandom_range(1) == 1) begin
                    // Same table index as the previous site, different tag.
                    site_pc[i] = site_pc[i-1] ^ ($urandom << IDX_W);
                end else begin
                    site_pc[i] = $urandom;
                end
                site_pat[i] = 8'($urandom);
                site_len[i] = $urandom_range(8, 1);
                site_pos[i] = 0;
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                k    = $urandom_range(POOL - 1);
                if (pick < 70) begin
                    addr        = site_pc[k];
                    tk          = site_pat[k][site_pos[k]];
                    site_pos[k] = (site_pos[k] + 1) % site_len[k];
                end else if (pick < 90) begin
                    addr = site_pc[k] ^ (32'd1 << $urandom_range(31));
                    tk   = ($urandom_range(3) != 0);
                end else begin
                    addr = $urandom;
                    tk   = 1'($urandom_range(1));
                end
                send_branch(addr, tk);
            end
        end

        // Everything has been sent: collect the remaining results and let
        // the block settle before the verdict.
        drain_results();
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("** tournament_branch_predictor_top: PASSED **");
        end else begin
            $display("** tournament_branch_predictor_top: FAILED **");
        end
        $finish;
    end

endmodule
